### src/rpf_pkg.sv
// Shared types, constants and functions for the radio packet framer.
// Holds the CRC-16 step, the transmit microcode table and the channel codes.
// No dependencies.
`timescale 1ns / 1ps

package rpf_pkg;

    // Payload limits and store geometry.
    localparam int          TX_ADDR_W      = 5;
    localparam int          RX_REM_W       = 7;
    localparam logic [TX_ADDR_W-1:0] TX_MAX_PAYLOAD = 5'd25;
    localparam logic [RX_REM_W-1:0]  RX_MAX_PAYLOAD = 7'd66;

    // Protocol constants.
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INVERT     = 16'hFFFF;
    localparam logic [15:0] SYNC_RESET     = 16'h2DD4;
    localparam logic [15:0] CRC_RESET      = 16'h1D0F;
    localparam logic [7:0]  FIFO_WRITE_CMD = 8'h06;

    // Configuration port.
    localparam int          CFG_INDEX_W    = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_WORD = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_START = 8'd1;

    // Input operation and result kind codes.
    localparam logic OP_TX = 1'b0;

    typedef enum logic [1:0] {
        KIND_TX_BYTE = 2'd0,
        KIND_RX_BYTE = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    // Receive phases.
    typedef enum logic [1:0] {
        RX_LEN    = 2'd0,
        RX_DATA   = 2'd1,
        RX_CRC_HI = 2'd2,
        RX_CRC_LO = 2'd3
    } t_rx_phase;

    // Microcode: byte source, jump kind and the control word.
    typedef enum logic [3:0] {
        SRC_CMD,
        SRC_BITCNT,
        SRC_ZERO,
        SRC_SYNC_HI,
        SRC_SYNC_LO,
        SRC_LEN,
        SRC_DATA,
        SRC_CRC_HI,
        SRC_CRC_LO
    } t_src;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_MORE,
        JMP_END
    } t_jmp;

    localparam int UC_PC_W = 4;
    localparam logic [UC_PC_W-1:0] UC_FETCH = 4'd8;

    typedef struct packed {
        t_src               src;
        logic               emit;
        logic               crc_upd;
        logic               rd;
        logic               idx_inc;
        logic               last;
        t_jmp               jmp;
        logic [UC_PC_W-1:0] target;
    } t_uword;

    // Store write request from the input side.
    typedef struct packed {
        logic                 we;
        logic [TX_ADDR_W-1:0] addr;
        logic [7:0]           data;
    } t_store_wr;

    // Frame start request.
    typedef struct packed {
        logic                 go;
        logic [TX_ADDR_W-1:0] count;
    } t_tx_start;

    // One frame byte offered by the sequencer.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_tx_emit;

    // One byte through the CCITT CRC, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Frame program: header, length, a fetch/send loop over the payload, CRC.
    function automatic t_uword ucode(input logic [UC_PC_W-1:0] pc);
        t_uword w;
        w = '{src: SRC_ZERO, emit: 1'b1, crc_upd: 1'b0, rd: 1'b0, idx_inc: 1'b0,
              last: 1'b0, jmp: JMP_NEXT, target: '0};
        unique case (pc)
            4'd0:  w.src = SRC_CMD;
            4'd1:  w.src = SRC_BITCNT;
            4'd2:  w.src = SRC_ZERO;
            4'd3:  w.src = SRC_ZERO;
            4'd4:  w.src = SRC_ZERO;
            4'd5:  w.src = SRC_SYNC_HI;
            4'd6:  w.src = SRC_SYNC_LO;
            4'd7: begin
                w.src     = SRC_LEN;
                w.crc_upd = 1'b1;
            end
            4'd8: begin
                w.emit = 1'b0;
                w.rd   = 1'b1;
            end
            4'd9: begin
                w.src     = SRC_DATA;
                w.crc_upd = 1'b1;
                w.idx_inc = 1'b1;
                w.jmp     = JMP_MORE;
                w.target  = UC_FETCH;
            end
            4'd10: w.src = SRC_CRC_HI;
            4'd11: begin
                w.src  = SRC_CRC_LO;
                w.last = 1'b1;
                w.jmp  = JMP_END;
            end
            default: w.jmp = JMP_END;
        endcase
        return w;
    endfunction

endpackage

### src/rpf_tx_seq.sv
// Transmit frame sequencer: payload store, microcode step counter and datapath.
// Depends on rpf_pkg for the control word table and the CRC step.
`timescale 1ns / 1ps

module rpf_tx_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpf_pkg::t_store_wr i_wr,
    input  rpf_pkg::t_tx_start i_start,
    input  logic [15:0]        i_sync_word,
    input  logic [15:0]        i_crc_start,
    input  logic               i_out_free,
    output logic               o_busy,
    output rpf_pkg::t_tx_emit  o_emit
);
    import rpf_pkg::*;

    logic [7:0]           r_mem [0:(1 << TX_ADDR_W)-1];
    logic [7:0]           r_rd;
    logic                 r_busy;
    logic [UC_PC_W-1:0]   r_pc;
    logic [TX_ADDR_W-1:0] r_idx;
    logic [TX_ADDR_W-1:0] r_n;
    logic [15:0]          r_crc;

    t_uword               w;
    logic                 advance;
    logic [7:0]           tx_byte;
    logic [TX_ADDR_W-1:0] idx_plus;
    logic [TX_ADDR_W-1:0] n_plus8;

    assign w        = ucode(r_pc);
    assign advance  = r_busy && (!w.emit || i_out_free);
    assign idx_plus = r_idx + 1'b1;
    assign n_plus8  = r_n + TX_ADDR_W'(8);

    // Byte source selection for the current step.
    always_comb begin
        unique case (w.src)
            SRC_CMD:     tx_byte = FIFO_WRITE_CMD;
            SRC_BITCNT:  tx_byte = {n_plus8, 3'b000} - 8'd1;
            SRC_SYNC_HI: tx_byte = i_sync_word[15:8];
            SRC_SYNC_LO: tx_byte = i_sync_word[7:0];
            SRC_LEN:     tx_byte = {3'b000, r_n};
            SRC_DATA:    tx_byte = r_rd;
            SRC_CRC_HI:  tx_byte = ~r_crc[15:8];
            SRC_CRC_LO:  tx_byte = ~r_crc[7:0];
            default:     tx_byte = 8'h00;
        endcase
    end

    assign o_busy       = r_busy;
    assign o_emit.valid = r_busy && w.emit;
    assign o_emit.data  = tx_byte;
    assign o_emit.last  = w.last;

    // Payload store: written from the input side, read by the fetch step.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (advance && w.rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // Step counter and branch logic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (!r_busy) begin
            if (i_start.go) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
            end
        end else if (advance) begin
            unique case (w.jmp)
                JMP_NEXT: r_pc <= r_pc + 1'b1;
                JMP_MORE: r_pc <= (idx_plus != r_n) ? w.target : r_pc + 1'b1;
                JMP_END:  r_busy <= 1'b0;
                default:  r_busy <= 1'b0;
            endcase
        end
    end

    // Datapath registers: length, payload index and running CRC.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start.go) begin
            r_n   <= i_start.count;
            r_idx <= '0;
            r_crc <= i_crc_start;
        end else if (advance) begin
            if (w.crc_upd) begin
                r_crc <= crc16_byte(r_crc, tx_byte);
            end
            if (w.idx_inc) begin
                r_idx <= idx_plus;
            end
        end
    end

endmodule

### src/radio_packet_framer_crc16_core.sv
// Radio packet framer top level: input decode, receive path, config, output register.
// Depends on rpf_pkg and rpf_tx_seq.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  payload or received byte
//  m_axis    out        m_axis_tvalid / m_axis_tready  frame byte, rx byte, status
//  cfg       in         i_cfg_valid / o_cfg_ready      register index and value
//
//  A final transmit beat starts the frame program, in which each payload byte
//  needs a fetch step and a send step.
//  Reset clears control state only; the payload store needs no clearing.
//  A full output register holds the sequencer on its current emit step, and
//  input is refused while a frame is being sent.

module radio_packet_framer_crc16_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                      s_axis_tuser,   // [0] operation
    input  logic                            s_axis_tlast,   // end_of_payload
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]                      m_axis_tuser,   // [1:0] out_kind, [2] crc_error
    output logic                            m_axis_tlast,   // last_of_run
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rpf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import rpf_pkg::*;

    logic [15:0]          r_sync_word;
    logic [15:0]          r_crc_start;
    logic [TX_ADDR_W-1:0] r_tx_count;
    t_rx_phase            r_rx_phase;
    t_rx_phase            n_rx_phase;
    logic [RX_REM_W-1:0]  r_rx_rem;
    logic [RX_REM_W-1:0]  n_rx_rem;
    logic [15:0]          r_rx_crc;
    logic [15:0]          n_rx_crc;

    logic                 r_m_valid;
    logic [7:0]           r_m_data;
    t_kind                r_m_kind;
    logic                 r_m_err;
    logic                 r_m_last;

    logic                 out_free;
    logic                 busy;
    logic                 in_beat;
    logic                 tx_beat;
    logic                 rx_beat;
    logic                 room;
    logic [TX_ADDR_W-1:0] tx_count_next;
    t_store_wr            store_wr;
    t_tx_start            tx_start;
    t_tx_emit             tx_emit;

    logic [15:0]          rx_crc_in;
    logic [15:0]          rx_crc_step;
    logic [RX_REM_W-1:0]  rx_len_clamp;
    logic [RX_REM_W-1:0]  rx_rem_dec;
    logic                 rx_out;
    logic [7:0]           rx_out_data;
    t_kind                rx_out_kind;
    logic                 rx_out_err;
    logic                 rx_out_last;

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = !busy && out_free;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign tx_beat       = in_beat && (s_axis_tuser[0] == OP_TX);
    assign rx_beat       = in_beat && (s_axis_tuser[0] != OP_TX);
    assign o_cfg_ready   = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word <= SYNC_RESET;
            r_crc_start <= CRC_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SYNC_WORD) begin
                r_sync_word <= i_cfg_data;
            end else if (i_cfg_index == CFG_CRC_START) begin
                r_crc_start <= i_cfg_data;
            end
        end
    end

    // Transmit collection: store while there is room, start a frame on the last beat.
    assign room          = r_tx_count < TX_MAX_PAYLOAD;
    assign tx_count_next = room ? r_tx_count + 1'b1 : r_tx_count;

    assign store_wr.we    = tx_beat && room;
    assign store_wr.addr  = r_tx_count;
    assign store_wr.data  = s_axis_tdata;
    assign tx_start.go    = tx_beat && s_axis_tlast;
    assign tx_start.count = tx_count_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_count <= '0;
        end else if (tx_beat) begin
            r_tx_count <= s_axis_tlast ? '0 : tx_count_next;
        end
    end

    rpf_tx_seq u_tx_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (store_wr),
        .i_start     (tx_start),
        .i_sync_word (r_sync_word),
        .i_crc_start (r_crc_start),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_emit      (tx_emit)
    );

    // Receive path: next phase, CRC and result for one received byte.
    assign rx_crc_in    = (r_rx_phase == RX_LEN) ? r_crc_start : r_rx_crc;
    assign rx_crc_step  = crc16_byte(rx_crc_in, s_axis_tdata);
    assign rx_len_clamp = (s_axis_tdata > {1'b0, RX_MAX_PAYLOAD}) ? RX_MAX_PAYLOAD
                                                                  : s_axis_tdata[RX_REM_W-1:0];
    assign rx_rem_dec   = r_rx_rem - 1'b1;

    always_comb begin
        n_rx_phase  = r_rx_phase;
        n_rx_rem    = r_rx_rem;
        n_rx_crc    = r_rx_crc;
        rx_out      = 1'b0;
        rx_out_data = s_axis_tdata;
        rx_out_kind = KIND_RX_BYTE;
        rx_out_err  = 1'b0;
        rx_out_last = 1'b0;
        if (rx_beat) begin
            unique case (r_rx_phase)
                RX_LEN: begin
                    n_rx_rem = rx_len_clamp;
                    if (rx_len_clamp == '0) begin
                        n_rx_crc   = rx_crc_step ^ CRC_INVERT;
                        n_rx_phase = RX_CRC_HI;
                    end else begin
                        n_rx_crc   = rx_crc_step;
                        n_rx_phase = RX_DATA;
                    end
                end
                RX_DATA: begin
                    rx_out   = 1'b1;
                    n_rx_rem = rx_rem_dec;
                    if (rx_rem_dec == '0) begin
                        n_rx_crc   = rx_crc_step ^ CRC_INVERT;
                        n_rx_phase = RX_CRC_HI;
                    end else begin
                        n_rx_crc   = rx_crc_step;
                    end
                end
                RX_CRC_HI: begin
                    n_rx_crc   = rx_crc_step;
                    n_rx_phase = RX_CRC_LO;
                end
                RX_CRC_LO: begin
                    rx_out      = 1'b1;
                    rx_out_data = 8'h00;
                    rx_out_kind = KIND_STATUS;
                    rx_out_err  = (rx_crc_step != 16'h0000);
                    rx_out_last = 1'b1;
                    n_rx_phase  = RX_LEN;
                    n_rx_rem    = '0;
                    n_rx_crc    = r_crc_start;
                end
                default: n_rx_phase = RX_LEN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_phase <= RX_LEN;
            r_rx_rem   <= '0;
            r_rx_crc   <= CRC_RESET;
        end else begin
            r_rx_phase <= n_rx_phase;
            r_rx_rem   <= n_rx_rem;
            r_rx_crc   <= n_rx_crc;
        end
    end

    // Output register: loaded from the sequencer or from the receive path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= tx_emit.valid || rx_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (tx_emit.valid) begin
                r_m_data <= tx_emit.data;
                r_m_kind <= KIND_TX_BYTE;
                r_m_err  <= 1'b0;
                r_m_last <= tx_emit.last;
            end else if (rx_out) begin
                r_m_data <= rx_out_data;
                r_m_kind <= rx_out_kind;
                r_m_err  <= rx_out_err;
                r_m_last <= rx_out_last;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = {r_m_err, r_m_kind};
    assign m_axis_tlast  = r_m_last;

endmodule
